// ----- hw/rtl/cvmt_pkg.sv -----
// Shared types, constants and codes for the counted value multiset table.
package cvmt_pkg;

  // Table geometry.
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int VALUE_BITS = 32;
  localparam int TOTAL_BITS = 20;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Status codes carried in the result.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  typedef logic [VALUE_BITS-1:0] key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [TOTAL_BITS-1:0] total_t;

  localparam count_t COUNT_MAX = '1;

  // One command as it arrives on the input port.
  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  value;
  } cmd_t;

  // One result as it leaves on the output port.
  typedef struct packed {
    logic        present;
    logic [15:0] value_count;
    logic [19:0] total_size;
    logic        is_empty;
    logic [1:0]  status;
  } result_t;

  // Outcome of the parallel search, passed from the lookup to the table.
  typedef struct packed {
    logic   hit;
    idx_t   hit_idx;
    count_t hit_count;
    logic   free_found;
    idx_t   free_idx;
  } lookup_t;

  // Only the low VALUE_BITS bits of a value take part in storage and matching.
  function automatic key_t to_key(logic signed [31:0] v);
    return VALUE_BITS'($unsigned(v));
  endfunction

endpackage

// ----- hw/rtl/cvmt_lookup.sv -----
// Parallel search of all table slots: matching slot and lowest free slot.
module cvmt_lookup
  import cvmt_pkg::*;
(
  input  key_t    key,
  input  key_t    entry_value [ENTRIES],
  input  count_t  entry_count [ENTRIES],
  output lookup_t lk
);

  always_comb begin
    lk = '0;
    // Stored values are distinct, so at most one slot matches and an OR merge is enough.
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_count[i] != '0 && entry_value[i] == key) begin
        lk.hit       = 1'b1;
        lk.hit_idx   = lk.hit_idx | IDX_BITS'(i);
        lk.hit_count = lk.hit_count | entry_count[i];
      end
    end
    // Walk downwards so the lowest free slot wins.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_count[i] == '0) begin
        lk.free_found = 1'b1;
        lk.free_idx   = IDX_BITS'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/cvmt_table.sv -----
// Slot storage, count update and running total, with the next result word.
module cvmt_table
  import cvmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  input  logic [1:0] mode,
  input  key_t       key,
  input  lookup_t    lk,
  output key_t       entry_value [ENTRIES],
  output count_t     entry_count [ENTRIES],
  output result_t    res_next
);

  count_t     count_next [ENTRIES];
  total_t     total;
  total_t     total_next;
  logic       write_en;
  logic [1:0] status;
  count_t     cnt_after;
  logic       empty_after;

  always_comb begin
    count_next = entry_count;
    total_next = total;
    write_en   = 1'b0;
    status     = STATUS_OK;
    cnt_after  = '0;
    if (valid) begin
      case (mode)
        MODE_ADD: begin
          if (lk.hit) begin
            if (lk.hit_count == COUNT_MAX) begin
              status    = STATUS_SATURATED;
              cnt_after = lk.hit_count;
            end else begin
              cnt_after               = count_t'(lk.hit_count + 1'b1);
              count_next[lk.hit_idx]  = cnt_after;
              total_next              = total_t'(total + 1'b1);
            end
          end else if (lk.free_found) begin
            cnt_after               = count_t'(1);
            count_next[lk.free_idx] = cnt_after;
            write_en                = 1'b1;
            total_next              = total_t'(total + 1'b1);
          end else begin
            status = STATUS_FULL;
          end
        end
        MODE_REMOVE: begin
          if (lk.hit) begin
            cnt_after              = count_t'(lk.hit_count - 1'b1);
            count_next[lk.hit_idx] = cnt_after;
            total_next             = total_t'(total - 1'b1);
          end
        end
        MODE_QUERY: begin
          cnt_after = lk.hit_count;
        end
        MODE_CLEAR: begin
          for (int i = 0; i < ENTRIES; i++) begin
            count_next[i] = '0;
          end
          total_next = '0;
        end
        default: begin
        end
      endcase
    end

    empty_after = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (count_next[i] != '0) begin
        empty_after = 1'b0;
      end
    end

    res_next.present     = (cnt_after != '0);
    res_next.value_count = 16'(cnt_after);
    res_next.total_size  = 20'(total_next);
    res_next.is_empty    = empty_after;
    res_next.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_count[i] <= '0;
      end
      total <= '0;
    end else begin
      entry_count <= count_next;
      total       <= total_next;
    end
  end

  // Values are only read behind a nonzero count, so they need no reset.
  always_ff @(posedge clk) begin
    if (write_en) begin
      entry_value[lk.free_idx] <= key;
    end
  end

endmodule

// ----- hw/rtl/counted_value_multiset_table.sv -----
// Top level of the counted value multiset table: command register, search, update, result.
//
//   Channel   Signals               Direction  Transfer
//   command   start, busy, cmd      in         start high and busy low at a rising edge
//   result    done, result          out        done high for one cycle, always taken
//
// Every command passes from transfer to result through the command register, which takes
// it, and the result register, loaded at the same edge that updates the table,
// after which done is high for exactly one cycle. A new command can be taken at every
// edge while busy is low, since the table is updated at the edge that registers the next one.
// The reset is synchronous; busy stays high for the cycle after reset is released.
// The receiver cannot stall: done marks each result on the ports for one cycle only.
module counted_value_multiset_table
  import cvmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  // Command register. It only needs a valid flag under reset; the payload follows it.
  logic    stage_valid;
  cmd_t    stage_cmd;
  key_t    stage_key;

  // Table contents as seen by the search, and the search outcome.
  key_t    entry_value [ENTRIES];
  count_t  entry_count [ENTRIES];
  lookup_t lk;
  result_t res_next;

  logic    accept;

  assign accept    = start && !busy;
  assign stage_key = to_key(stage_cmd.value);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      stage_valid <= 1'b0;
    end else begin
      busy        <= 1'b0;
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cmd;
    end
  end

  // All slots are compared with the registered key at once; the lookup also finds the
  // lowest free slot in case an add has to place a new value.
  cvmt_lookup u_lookup (
    .key         (stage_key),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .lk          (lk)
  );

  // The table applies at most one count change (or a full clear) and works out the
  // result word from the state as it will be after this command.
  cvmt_table u_table (
    .clk         (clk),
    .rst         (rst),
    .valid       (stage_valid),
    .mode        (stage_cmd.mode),
    .key         (stage_key),
    .lk          (lk),
    .entry_value (entry_value),
    .entry_count (entry_count),
    .res_next    (res_next)
  );

  // Result register: done is a one-cycle strobe, the payload is only loaded with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      result <= res_next;
    end
  end

  // Every accepted command yields its result, through the command and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command produced no result");

  // No result appears without a matching command accepted earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching command");

  // A dropped add means the table was full, so it cannot be empty nor hold the value.
  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_FULL) |-> (!result.is_empty && !result.present))
    else $error("full status with an empty table or a present value");

  // An empty table holds nothing at all.
  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.total_size == '0 && !result.present))
    else $error("empty table with a nonzero total or a present value");

endmodule

// ----- verif/counted_value_multiset_table_tb.sv -----
// Self-checking testbench for the counted value multiset table, with its own table predictor.
`timescale 1ns / 100ps

module counted_value_multiset_table_tb;
  import cvmt_pkg::*;

  // A quiet stretch this long means the block has stopped taking commands or giving
  // results. The sender's legal quiet spells are random gaps far shorter than this, so this
  // leaves a wide margin.
  localparam int QUIET_LIMIT = 1000;
  localparam int POOL_SIZE   = 20;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  // The predictor's own copy of the table: the value and copy count of each slot, and the
  // running total of all counts.
  key_t    held_key   [ENTRIES];
  count_t  held_count [ENTRIES];
  total_t  held_total;

  // Results that have been predicted for accepted commands and not yet seen on the ports.
  result_t awaited_tallies[$];

  int fail_count      = 0;
  int quiet_cycles    = 0;
  int sender_idle_pct = 0;

  counted_value_multiset_table u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Returns the slot that holds the key, or -1. Free slots are never matched, so a slot
  // whose key was never written is never looked at.
  function automatic int slot_holding(key_t k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (held_count[i] != '0 && held_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one command to the predicted table and returns the result it should produce.
  function automatic result_t tally_after_op(cmd_t c);
    result_t r;
    key_t    k;
    int      hit;
    int      free_slot;
    logic    any_held;
    r = '0;
    k = c.value;
    free_slot = -1;
    any_held = 1'b0;
    r.status = STATUS_OK;
    if (c.mode == MODE_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) held_count[i] = '0;
      held_total = '0;
    end else begin
      hit = slot_holding(k);
      if (c.mode == MODE_ADD) begin
        if (hit >= 0) begin
          if (held_count[hit] == COUNT_MAX) begin
            r.status = STATUS_SATURATED;
          end else begin
            held_count[hit] = held_count[hit] + 1'b1;
            held_total = held_total + 1'b1;
          end
        end else begin
          // A new value goes into the lowest-numbered free slot.
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (held_count[i] == '0) free_slot = i;
          end
          if (free_slot < 0) begin
            r.status = STATUS_FULL;
          end else begin
            held_key[free_slot] = k;
            held_count[free_slot] = count_t'(1);
            held_total = held_total + 1'b1;
          end
        end
      end else if (c.mode == MODE_REMOVE && hit >= 0) begin
        // A count that falls to zero frees its slot by itself.
        held_count[hit] = held_count[hit] - 1'b1;
        held_total = held_total - 1'b1;
      end
      hit = slot_holding(k);
      if (hit >= 0) r.value_count = held_count[hit];
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (held_count[i] != '0) any_held = 1'b1;
    end
    r.present    = (r.value_count != '0);
    r.total_size = held_total;
    r.is_empty   = !any_held;
    return r;
  endfunction

  // Offers one command. Before it the sender may idle for a while, as the current phase
  // asks; start then stays high from one transfer to the next unless a gap is drawn, so it
  // is never lowered and raised within the same time step.
  task automatic send_op(input logic [1:0] mode, input logic signed [31:0] val);
    cmd_t c;
    c.mode  = mode;
    c.value = val;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The transfer took place at this edge: predict its result in order of acceptance.
    awaited_tallies.push_back(tally_after_op(c));
  endtask

  // Holds the sender off until every predicted result has come back, then lets the last
  // result's pipeline settle.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_tallies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The extremes of the value field, the special cases of remove and of a freed slot, and
  // clear both on an occupied and on an empty table.
  task automatic test_basic_ops();
    send_op(MODE_ADD,    32'h8000_0000);
    send_op(MODE_ADD,    32'h7FFF_FFFF);
    send_op(MODE_ADD,    32'h7FFF_FFFF);
    send_op(MODE_QUERY,  32'h7FFF_FFFF);
    send_op(MODE_REMOVE, 32'h0000_0000);      // absent value: nothing changes
    send_op(MODE_REMOVE, 32'h8000_0000);      // count falls to zero and the slot is freed
    send_op(MODE_QUERY,  32'h8000_0000);
    send_op(MODE_ADD,    32'hFFFF_FFFF);
    send_op(MODE_CLEAR,  $urandom);           // value is ignored by a clear
    send_op(MODE_QUERY,  32'h7FFF_FFFF);
    send_op(MODE_CLEAR,  32'hFFFF_FFFF);      // clear of an already empty table
  endtask

  // Fills every slot, tries one value too many, then frees a slot in the middle so that
  // the new value has to land there.
  task automatic test_full_table();
    for (int i = 0; i < ENTRIES; i++) send_op(MODE_ADD, i * 32'h0F0F_0F0F + 32'd7);
    send_op(MODE_ADD,    32'h7654_3210);
    send_op(MODE_REMOVE, 3 * 32'h0F0F_0F0F + 32'd7);
    send_op(MODE_ADD,    32'h7654_3210);
    send_op(MODE_QUERY,  32'h7654_3210);
  endtask

  // Random commands. Most values come from a small pool a little larger than the table, so
  // that adds and removes meet the same values, counts grow and the table fills up; the
  // rest are arbitrary values. Once mid-phase, and again at its end, the sender waits for every result.
  task automatic test_random_traffic(input int n_ops, input int idle_pct);
    logic signed [31:0] value_pool[POOL_SIZE];
    logic signed [31:0] val;
    logic [1:0]         mode;
    int                 pick;
    int                 pause_at;
    sender_idle_pct = idle_pct;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
    pause_at = $urandom_range(n_ops - 1);
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(99);
      if (pick < 48)      mode = MODE_ADD;
      else if (pick < 78) mode = MODE_REMOVE;
      else if (pick < 98) mode = MODE_QUERY;
      else                mode = MODE_CLEAR;
      if ($urandom_range(99) < 85) val = value_pool[$urandom_range(POOL_SIZE - 1)];
      else                         val = $urandom;
      send_op(mode, val);
      if (i == pause_at) wait_until_drained();
    end
    wait_until_drained();
  endtask

  // Every strobed result is taken at the edge that ends its cycle and compared, field by
  // field, with the oldest prediction.
  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (awaited_tallies.size() == 0) begin
        $error("result strobed with no command outstanding");
        fail_count++;
      end else begin
        exp = awaited_tallies.pop_front();
        check_field("present",     32'(exp.present),     32'(result.present));
        check_field("value_count", 32'(exp.value_count), 32'(result.value_count));
        check_field("total_size",  32'(exp.total_size),  32'(result.total_size));
        check_field("is_empty",    32'(exp.is_empty),    32'(result.is_empty));
        check_field("status",      32'(exp.status),      32'(result.status));
      end
    end
  end

  // Watchdog: a cycle with neither a command transfer nor a result counts as quiet.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) held_count[i] = '0;
    held_total = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_full_table();
    wait_until_drained();
    // Three phases of traffic: back to back, a sender that is mostly idle, and a sender
    // that idles now and then. The receiver has no way to stall, so no phase throttles it.
    test_random_traffic(700, 0);
    test_random_traffic(650, 71);
    test_random_traffic(650, 27);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
